FILE: rtl/byte_stack_with_search_assert.svh
// assertion macros for the byte stack block
`ifndef BYTE_STACK_WITH_SEARCH_ASSERT_SVH
`define BYTE_STACK_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define BSWS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsws: same-cycle check failed");
`define BSWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsws: next-cycle check failed");
`else
`define BSWS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BSWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/bsws_pkg.sv
package bsws_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int OP_W          = 3;
   localparam int DATA_W        = 8;
   localparam int POS_W         = 6;
   localparam int STATUS_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_TOP    = 3'd2,
      OP_REMOVE = 3'd3,
      OP_FIND   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [POS_W-1:0]    position;
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    fill;
      logic                last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH,
      S_RDTOP,
      S_RDOUT,
      S_RM_RD,
      S_RM_CMP,
      S_FD_RD,
      S_FD_CMP,
      S_FD_LAST,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_TOP,
      RD_UP,
      RD_DOWN
   } rd_sel_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_PUSH,
      RSP_POP,
      RSP_TOP,
      RSP_PLAIN,
      RSP_MATCH
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         scan_down;
      logic         push;
      rd_sel_type   rd;
      logic         rm_step;
      logic         rm_finish;
      logic         fd_step;
      rsp_kind_type emit;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic            up_done;
      logic            down_done;
      logic            match;
      logic            pend;
      logic            rsp_free;
      logic [OP_W-1:0] op;
   } stat_type;

endpackage

FILE: rtl/bsws_ctrl.sv
module bsws_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [bsws_pkg::OP_W-1:0]   req_op,
   output logic                        req_ready,
   input  bsws_pkg::stat_type          st,
   output bsws_pkg::cmd_type           cmd
);
   import bsws_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd    = RD_NONE;
      cmd.emit  = RSP_NONE;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load      = req_valid;
            cmd.scan_down = (req_op == OP_FIND);
            if (req_valid) begin
               case (req_op)
                  OP_PUSH:   state_in = S_PUSH;
                  OP_POP:    state_in = S_RDTOP;
                  OP_TOP:    state_in = S_RDTOP;
                  OP_REMOVE: state_in = S_RM_RD;
                  OP_FIND:   state_in = S_FD_RD;
                  default:   state_in = S_EMIT;
               endcase
            end
         end
         S_PUSH: begin
            if (st.rsp_free) begin
               cmd.push = 1'b1;
               cmd.emit = RSP_PUSH;
               state_in = S_IDLE;
            end
         end
         S_RDTOP: begin
            cmd.rd   = RD_TOP;
            state_in = S_RDOUT;
         end
         S_RDOUT: begin
            if (st.rsp_free) begin
               cmd.emit = (st.op == OP_POP) ? RSP_POP : RSP_TOP;
               state_in = S_IDLE;
            end
         end
         S_RM_RD: begin
            if (st.up_done) begin
               cmd.rm_finish = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cmd.rd   = RD_UP;
               state_in = S_RM_CMP;
            end
         end
         S_RM_CMP: begin
            cmd.rm_step = 1'b1;
            state_in    = S_RM_RD;
         end
         S_FD_RD: begin
            if (st.down_done) begin
               state_in = st.pend ? S_FD_LAST : S_EMIT;
            end else begin
               cmd.rd   = RD_DOWN;
               state_in = S_FD_CMP;
            end
         end
         S_FD_CMP: begin
            if (st.match && st.pend) begin
               if (st.rsp_free) begin
                  cmd.emit    = RSP_MATCH;
                  cmd.fd_step = 1'b1;
                  state_in    = S_FD_RD;
               end
            end else begin
               cmd.fd_step = 1'b1;
               state_in    = S_FD_RD;
            end
         end
         S_FD_LAST: begin
            if (st.rsp_free) begin
               cmd.emit      = RSP_MATCH;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit = RSP_PLAIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/bsws_dp.sv
module bsws_dp #(
   parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bsws_pkg::req_type    req_data,
   input  bsws_pkg::cmd_type    cmd,
   output bsws_pkg::stat_type   st,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bsws_pkg::rsp_type    rsp_data
);
   import bsws_pkg::*;
   `include "byte_stack_with_search_assert.svh"

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

   logic [DATA_W-1:0] stack_store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, kept_ff, pend_pos_ff;
   logic [DATA_W-1:0] value_ff;
   logic [OP_W-1:0]   op_ff;
   logic              found_ff, pend_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              empty, full, match, rsp_free;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == COUNT_MAX);
   assign match    = (rd_data_ff == value_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // single write port shared by push and compaction
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = value_ff;
      if (cmd.push && !full) begin
         wr_en = 1'b1;
      end else if (cmd.rm_step && !match) begin
         wr_en   = 1'b1;
         wr_addr = kept_ff[AW-1:0];
         wr_data = rd_data_ff;
      end
   end

   always_comb begin
      case (cmd.rd)
         RD_TOP:  rd_addr = AW'(count_ff - 1'b1);
         RD_UP:   rd_addr = idx_ff[AW-1:0];
         RD_DOWN: rd_addr = AW'(idx_ff - 1'b1);
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd != RD_NONE) begin
         rd_data_ff <= stack_store_ff[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push && !full) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.emit == RSP_POP && !empty) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.rm_finish) begin
         count_in = kept_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_data.value;
         op_ff    <= req_data.op;
         idx_ff   <= cmd.scan_down ? count_ff : '0;
         kept_ff  <= '0;
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end
      if (cmd.rm_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (match) begin
            found_ff <= 1'b1;
         end else begin
            kept_ff <= kept_ff + 1'b1;
         end
      end
      if (cmd.fd_step) begin
         idx_ff <= idx_ff - 1'b1;
         if (match) begin
            found_ff    <= 1'b1;
            pend_ff     <= 1'b1;
            pend_pos_ff <= idx_ff;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      case (cmd.emit)
         RSP_PUSH: begin
            rsp_in.data     = value_ff;
            rsp_in.position = '0;
            rsp_in.hit      = 1'b0;
            rsp_in.status   = full ? ST_FULL : ST_OK;
            rsp_in.fill     = full ? POS_W'(count_ff) : POS_W'(count_ff + 1'b1);
            rsp_in.last     = 1'b1;
         end
         RSP_POP, RSP_TOP: begin
            rsp_in.position = '0;
            rsp_in.hit      = 1'b0;
            rsp_in.last     = 1'b1;
            if (empty) begin
               rsp_in.data   = '0;
               rsp_in.status = ST_EMPTY;
               rsp_in.fill   = POS_W'(count_ff);
            end else begin
               rsp_in.data   = rd_data_ff;
               rsp_in.status = ST_OK;
               rsp_in.fill   = (cmd.emit == RSP_POP) ? POS_W'(count_ff - 1'b1)
                                                     : POS_W'(count_ff);
            end
         end
         RSP_PLAIN: begin
            rsp_in.data     = value_ff;
            rsp_in.position = '0;
            rsp_in.hit      = found_ff;
            rsp_in.status   = ST_OK;
            rsp_in.fill     = POS_W'(count_ff);
            rsp_in.last     = 1'b1;
         end
         RSP_MATCH: begin
            rsp_in.data     = value_ff;
            rsp_in.position = POS_W'(pend_pos_ff);
            rsp_in.hit      = 1'b1;
            rsp_in.status   = ST_OK;
            rsp_in.fill     = POS_W'(count_ff);
            rsp_in.last     = cmd.emit_last;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit != RSP_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign st.up_done   = (idx_ff == count_ff);
   assign st.down_done = (idx_ff == '0);
   assign st.match     = match;
   assign st.pend      = pend_ff;
   assign st.rsp_free  = rsp_free;
   assign st.op        = op_ff;

   `BSWS_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_MAX)
   `BSWS_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit != RSP_NONE, rsp_free)
   `BSWS_ASSERT_IMP(a_kept_behind, clock, reset, cmd.rm_step, kept_ff <= idx_ff)
   `BSWS_ASSERT_NEXT(a_full_push, clock, reset, cmd.push && full, $stable(count_ff))

endmodule

FILE: rtl/byte_stack_with_search.sv
// channel   | ports                              | direction
// request   | req_valid, req_ready, req_data     | in
// response  | rsp_valid, rsp_ready, rsp_data     | out
//
// one request at a time; req_ready is high only while the controller is idle
// push passes through S_PUSH, pop and top through S_RDTOP and S_RDOUT, unknown
// ops through S_EMIT; remove-all and find walk the held entries one at a time,
// a read state then a compare state each, set by the single registered read port
// a full response register stalls the find walk; reset is synchronous and
// clears the entry count, the controller and the response valid
module byte_stack_with_search #(
   parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bsws_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bsws_pkg::rsp_type   rsp_data
);
   import bsws_pkg::*;

   cmd_type  cmd;
   stat_type st;

   bsws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   bsws_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/tb_byte_stack_with_search.sv
`timescale 1ns / 1ps

module tb_byte_stack_with_search;
   import bsws_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 375;
   localparam int BLOCK_ITEMS = 40;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BLEND
   } mix_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      logic [5:0]        reps;
      logic              typed;
      rsp_type           want;
   } dir_row_type;

   localparam rsp_type NO_WANT = '0;
   localparam int DIR_COUNT = 25;

   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{OP_POP,       8'h00, 6'd1,  1'b1, '{8'h00, 6'd0, 1'b0, ST_EMPTY, 6'd0,  1'b1}},
      '{OP_TOP,       8'h00, 6'd1,  1'b1, '{8'h00, 6'd0, 1'b0, ST_EMPTY, 6'd0,  1'b1}},
      '{OP_FIND,      8'h5a, 6'd1,  1'b1, '{8'h5a, 6'd0, 1'b0, ST_OK,    6'd0,  1'b1}},
      '{OP_REMOVE,    8'ha5, 6'd1,  1'b1, '{8'ha5, 6'd0, 1'b0, ST_OK,    6'd0,  1'b1}},
      '{OP_UNUSED_LO, 8'h3c, 6'd1,  1'b1, '{8'h3c, 6'd0, 1'b0, ST_OK,    6'd0,  1'b1}},
      '{OP_PUSH,      8'h00, 6'd1,  1'b1, '{8'h00, 6'd0, 1'b0, ST_OK,    6'd1,  1'b1}},
      '{OP_PUSH,      8'hff, 6'd1,  1'b1, '{8'hff, 6'd0, 1'b0, ST_OK,    6'd2,  1'b1}},
      '{OP_TOP,       8'h00, 6'd1,  1'b1, '{8'hff, 6'd0, 1'b0, ST_OK,    6'd2,  1'b1}},
      '{OP_POP,       8'h00, 6'd1,  1'b1, '{8'hff, 6'd0, 1'b0, ST_OK,    6'd1,  1'b1}},
      '{OP_POP,       8'h00, 6'd1,  1'b1, '{8'h00, 6'd0, 1'b0, ST_OK,    6'd0,  1'b1}},
      '{OP_PUSH,      8'h81, 6'd1,  1'b0, NO_WANT},
      '{OP_PUSH,      8'h42, 6'd1,  1'b0, NO_WANT},
      '{OP_PUSH,      8'h81, 6'd1,  1'b0, NO_WANT},
      '{OP_FIND,      8'h81, 6'd1,  1'b0, NO_WANT},
      '{OP_FIND,      8'h99, 6'd1,  1'b0, NO_WANT},
      '{OP_REMOVE,    8'h81, 6'd1,  1'b0, NO_WANT},
      '{OP_REMOVE,    8'h81, 6'd1,  1'b0, NO_WANT},
      '{OP_REMOVE,    8'h42, 6'd1,  1'b0, NO_WANT},
      '{OP_PUSH,      8'hff, 6'd32, 1'b0, NO_WANT},
      '{OP_PUSH,      8'hff, 6'd1,  1'b1, '{8'hff, 6'd0, 1'b0, ST_FULL,  6'd32, 1'b1}},
      '{OP_FIND,      8'hff, 6'd1,  1'b0, NO_WANT},
      '{OP_POP,       8'h00, 6'd1,  1'b0, NO_WANT},
      '{OP_UNUSED_HI, 8'hc3, 6'd1,  1'b0, NO_WANT},
      '{OP_REMOVE,    8'hff, 6'd1,  1'b0, NO_WANT},
      '{OP_POP,       8'h00, 6'd1,  1'b0, NO_WANT}
   };

   localparam logic [DATA_W-1:0] VALUE_POOL [4] = '{8'h00, 8'hff, 8'h55, 8'haa};

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [DATA_W-1:0] stack_mirror [STACK_DEPTH];
   int                mirror_fill;
   rsp_type           stack_answers [$];
   rsp_type           fresh_answers [$];
   int                errors;
   int                requests_sent;
   int                answers_seen;
   int                peak_fill;
   int                full_refusals;
   int                find_matches;

   byte_stack_with_search #(
      .DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_type make_rsp(logic [DATA_W-1:0] data, int pos, logic hit,
                                        status_type status, logic last);
      rsp_type x;
      x.data = data;
      x.position = pos[POS_W-1:0];
      x.hit = hit;
      x.status = status;
      x.fill = mirror_fill[POS_W-1:0];
      x.last = last;
      return x;
   endfunction

   // applies one request to the mirrored stack, answers land in fresh_answers
   function automatic void stack_op(req_type r);
      int kept;
      int match_total;
      int n;
      logic found;
      fresh_answers.delete();
      case (r.op)
         OP_PUSH: begin
            if (mirror_fill >= STACK_DEPTH) begin
               full_refusals++;
               fresh_answers.push_back(make_rsp(r.value, 0, 1'b0, ST_FULL, 1'b1));
            end else begin
               stack_mirror[mirror_fill] = r.value;
               mirror_fill++;
               if (mirror_fill > peak_fill) peak_fill = mirror_fill;
               fresh_answers.push_back(make_rsp(r.value, 0, 1'b0, ST_OK, 1'b1));
            end
         end
         OP_POP, OP_TOP: begin
            if (mirror_fill == 0) begin
               fresh_answers.push_back(make_rsp(8'h00, 0, 1'b0, ST_EMPTY, 1'b1));
            end else begin
               n = mirror_fill - 1;
               if (r.op == OP_POP) mirror_fill--;
               fresh_answers.push_back(make_rsp(stack_mirror[n], 0, 1'b0, ST_OK, 1'b1));
            end
         end
         OP_REMOVE: begin
            kept = 0;
            found = 1'b0;
            for (int i = 0; i < mirror_fill; i++) begin
               if (stack_mirror[i] == r.value) found = 1'b1;
               else begin
                  stack_mirror[kept] = stack_mirror[i];
                  kept++;
               end
            end
            mirror_fill = kept;
            fresh_answers.push_back(make_rsp(r.value, 0, found, ST_OK, 1'b1));
         end
         OP_FIND: begin
            match_total = 0;
            for (int i = 0; i < mirror_fill; i++)
               if (stack_mirror[i] == r.value) match_total++;
            if (match_total == 0) begin
               fresh_answers.push_back(make_rsp(r.value, 0, 1'b0, ST_OK, 1'b1));
            end else begin
               n = 0;
               for (int i = mirror_fill; i > 0; i--) begin
                  if (stack_mirror[i-1] == r.value) begin
                     n++;
                     find_matches++;
                     fresh_answers.push_back(make_rsp(r.value, i, 1'b1, ST_OK,
                                                      n == match_total));
                  end
               end
            end
         end
         default: begin
            fresh_answers.push_back(make_rsp(r.value, 0, 1'b0, ST_OK, 1'b1));
         end
      endcase
   endfunction

   function automatic int pick_gap(logic calm);
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // holds valid until the request is accepted, then updates the mirror
   task automatic send_req(req_type r, logic calm, logic typed, rsp_type want);
      int gap;
      gap = pick_gap(calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      stack_op(r);
      if (typed) stack_answers.push_back(want);
      else foreach (fresh_answers[k]) stack_answers.push_back(fresh_answers[k]);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   function automatic req_type draw_req(mix_type mix);
      req_type r;
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:
            r.op = roll < 75 ? OP_PUSH : roll < 82 ? OP_POP : roll < 88 ? OP_TOP :
                   roll < 93 ? OP_FIND : roll < 97 ? OP_REMOVE : OP_UNUSED_LO;
         MIX_DRAIN:
            r.op = roll < 15 ? OP_PUSH : roll < 60 ? OP_POP : roll < 72 ? OP_TOP :
                   roll < 85 ? OP_FIND : roll < 95 ? OP_REMOVE : OP_UNUSED_LO;
         default:
            r.op = roll < 40 ? OP_PUSH : roll < 58 ? OP_POP : roll < 68 ? OP_TOP :
                   roll < 83 ? OP_FIND : roll < 93 ? OP_REMOVE : OP_UNUSED_LO;
      endcase
      if (r.op == OP_UNUSED_LO) r.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      if ($urandom_range(0, 9) < 7) r.value = VALUE_POOL[2'($urandom_range(0, 3))];
      else r.value = DATA_W'($urandom_range(0, 255));
      return r;
   endfunction

   // response side: random stalls, each accepted response checked in order
   initial begin
      int gap;
      logic calm;
      rsp_type want;
      calm = 1'b0;
      @(negedge reset);
      forever begin
         if (answers_seen % 50 == 0) calm = ($urandom_range(0, 2) == 0);
         gap = pick_gap(calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         answers_seen++;
         if (stack_answers.size() == 0) begin
            $error("unexpected response: data %0d position %0d", rsp_data.data,
                   rsp_data.position);
            errors++;
         end else begin
            want = stack_answers.pop_front();
            check_field("data", want.data, rsp_data.data);
            check_field("position", want.position, rsp_data.position);
            check_field("hit", want.hit, rsp_data.hit);
            check_field("status", want.status, rsp_data.status);
            check_field("fill", want.fill, rsp_data.fill);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   initial begin
      mix_type mix;
      logic calm;
      errors = 0;
      requests_sent = 0;
      answers_seen = 0;
      peak_fill = 0;
      full_refusals = 0;
      find_matches = 0;
      mirror_fill = 0;
      foreach (stack_mirror[i]) stack_mirror[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[i])
         for (int rep = 0; rep < DIR_ROWS[i].reps; rep++)
            send_req('{op: DIR_ROWS[i].op, value: DIR_ROWS[i].value}, 1'b0,
                     DIR_ROWS[i].typed, DIR_ROWS[i].want);

      mix = MIX_BLEND;
      calm = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % BLOCK_ITEMS == 0) begin
            mix = mix_type'($urandom_range(0, 2));
            calm = ($urandom_range(0, 2) == 0);
         end
         send_req(draw_req(mix), calm, 1'b0, NO_WANT);
      end
      req_valid <= 1'b0;

      while (stack_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d responses, peak fill %0d of %0d",
               requests_sent, answers_seen, peak_fill, STACK_DEPTH);
      $display("full pushes refused %0d, find matches reported %0d, mismatches %0d",
               full_refusals, find_matches, errors);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
